@@ rtl/swcs_pkg.sv @@
`timescale 1ns / 1ps
// package for the stack with counting sort: request and result structs,
// action and status codes, default sizes; no dependencies
package swcs_pkg;

  // fixed field widths of the request and result channels
  localparam int unsigned ACT_W = 2;
  localparam int unsigned VAL_W = 8;
  localparam int unsigned CNT_W = 7;
  localparam int unsigned STS_W = 2;

  // default sizes for the top level parameters
  localparam int unsigned STACK_DEPTH_DEF = 64;
  localparam int unsigned VALUE_BITS_DEF  = 8;

  // action codes
  localparam logic [ACT_W-1:0] ACT_PUSH = 2'd0;
  localparam logic [ACT_W-1:0] ACT_POP  = 2'd1;
  localparam logic [ACT_W-1:0] ACT_SORT = 2'd2;

  // status codes
  localparam logic [STS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STS_W-1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic [ACT_W-1:0] action;
    logic [VAL_W-1:0] push_value;
  } in_item_t;

  typedef struct packed {
    logic [VAL_W-1:0] popped_value;
    logic [CNT_W-1:0] entry_count;
    logic [VAL_W-1:0] largest_value;
    logic [STS_W-1:0] status;
  } out_item_t;

endpackage

@@ rtl/stack_with_counting_sort.sv @@
`timescale 1ns / 1ps
// bounded lifo stack with in-place counting sort and running largest value
// depends on swcs_pkg
//
//  channel  ports                         payload
//  -------  ----------------------------  ----------------------
//  request  in_valid, in_ready, in_data   swcs_pkg::in_item_t
//  result   out_valid, out_ready, out_data swcs_pkg::out_item_t
//
// push, pop on empty, push on full, sort of fewer than two entries and the
// unused action answer straight from idle; a pop first reads the stack memory.
// a sort of N entries walks the memories: it clears all 2^VALUE_BITS histogram
// bins, counts each entry (read it, read its bin, write the bin plus one), then
// per value up to the largest reads the bin and refills one entry per count.
// each stack entry keeps the largest value at or below it, so the largest
// value after a pop comes from the same read as the popped value.
// reset (rst_n low, synchronous) empties the stack and the result register.
// a new request is taken only in idle with the result register free or
// being taken, so a finished result never waits on out_ready.
module stack_with_counting_sort #(
  parameter int unsigned STACK_DEPTH = swcs_pkg::STACK_DEPTH_DEF,
  parameter int unsigned VALUE_BITS  = swcs_pkg::VALUE_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  swcs_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output swcs_pkg::out_item_t out_data
);

  localparam int unsigned CW = $clog2(STACK_DEPTH + 1);
  localparam int unsigned AW = $clog2(STACK_DEPTH);
  localparam int unsigned VB = VALUE_BITS;
  localparam int unsigned HD = 1 << VALUE_BITS;

  typedef struct packed {
    logic [VB-1:0] pmax;
    logic [VB-1:0] val;
  } entry_t;

  typedef enum logic [8:0] {
    S_IDLE     = 9'b000000001,
    S_POP      = 9'b000000010,
    S_CLR      = 9'b000000100,
    S_CNT_RD   = 9'b000001000,
    S_CNT_HIST = 9'b000010000,
    S_CNT_WR   = 9'b000100000,
    S_FILL_RD  = 9'b001000000,
    S_FILL_LD  = 9'b010000000,
    S_FILL_WR  = 9'b100000000
  } state_t;

  // memories
  entry_t        stack_mem [STACK_DEPTH];
  logic [CW-1:0] hist_mem  [HD];

  entry_t        rd_a_r, rd_b_r;
  logic [CW-1:0] hist_rd_r;

  logic          stk_we, stk_re;
  logic [AW-1:0] stk_waddr, stk_raddr_a, stk_raddr_b;
  entry_t        stk_wdata;
  logic          hist_we, hist_re;
  logic [VB-1:0] hist_waddr, hist_raddr;
  logic [CW-1:0] hist_wdata;

  // control registers
  state_t        state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [VB-1:0] largest_r, largest_nxt;
  logic [AW-1:0] idx_r, idx_nxt;
  logic [VB-1:0] val_r, val_nxt;
  logic [CW-1:0] pos_r, pos_nxt;
  logic [CW-1:0] run_r, run_nxt;
  swcs_pkg::out_item_t out_r, out_nxt;
  logic          out_valid_r, out_valid_nxt;

  logic          in_fire;
  logic [VB-1:0] push_val;
  logic          out_load;
  logic [VB-1:0] res_pop;
  logic [swcs_pkg::STS_W-1:0] res_st;

  assign in_ready  = (state_r == S_IDLE) && (!out_valid_r || out_ready);
  assign in_fire   = in_valid && in_ready;
  assign push_val  = VB'(in_data.push_value);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // stack memory, one write and two registered reads
  always_ff @(posedge clk) begin
    if (stk_we) begin
      stack_mem[stk_waddr] <= stk_wdata;
    end
    if (stk_re) begin
      rd_a_r <= stack_mem[stk_raddr_a];
      rd_b_r <= stack_mem[stk_raddr_b];
    end
  end

  // histogram memory, one write and one registered read
  always_ff @(posedge clk) begin
    if (hist_we) begin
      hist_mem[hist_waddr] <= hist_wdata;
    end
    if (hist_re) begin
      hist_rd_r <= hist_mem[hist_raddr];
    end
  end

  // sequencer
  always_comb begin
    state_nxt   = state_r;
    count_nxt   = count_r;
    largest_nxt = largest_r;
    idx_nxt     = idx_r;
    val_nxt     = val_r;
    pos_nxt     = pos_r;
    run_nxt     = run_r;
    stk_we      = 1'b0;
    stk_re      = 1'b0;
    stk_waddr   = '0;
    stk_wdata   = '0;
    stk_raddr_a = '0;
    stk_raddr_b = '0;
    hist_we     = 1'b0;
    hist_re     = 1'b0;
    hist_waddr  = '0;
    hist_wdata  = '0;
    hist_raddr  = '0;
    out_load    = 1'b0;
    res_pop     = '0;
    res_st      = swcs_pkg::ST_OK;

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          case (in_data.action)
            swcs_pkg::ACT_PUSH: begin
              out_load = 1'b1;
              if (count_r == CW'(STACK_DEPTH)) begin
                res_st = swcs_pkg::ST_FULL;
              end else begin
                stk_we      = 1'b1;
                stk_waddr   = AW'(count_r);
                largest_nxt = (push_val > largest_r) ? push_val : largest_r;
                stk_wdata   = '{pmax: largest_nxt, val: push_val};
                count_nxt   = count_r + CW'(1);
              end
            end
            swcs_pkg::ACT_POP: begin
              if (count_r == '0) begin
                out_load = 1'b1;
                res_st   = swcs_pkg::ST_EMPTY;
              end else begin
                stk_re      = 1'b1;
                stk_raddr_a = AW'(count_r - CW'(1));
                stk_raddr_b = AW'(count_r - CW'(2));
                state_nxt   = S_POP;
              end
            end
            swcs_pkg::ACT_SORT: begin
              if (count_r < CW'(2)) begin
                out_load = 1'b1;
              end else begin
                val_nxt   = '0;
                state_nxt = S_CLR;
              end
            end
            default: begin
              out_load = 1'b1;
            end
          endcase
        end
      end
      // top entry and the largest value below it arrive together
      S_POP: begin
        out_load    = 1'b1;
        res_pop     = rd_a_r.val;
        count_nxt   = count_r - CW'(1);
        largest_nxt = (count_r > CW'(1)) ? rd_b_r.pmax : '0;
        state_nxt   = S_IDLE;
      end
      // clear the histogram
      S_CLR: begin
        hist_we    = 1'b1;
        hist_waddr = val_r;
        hist_wdata = '0;
        val_nxt    = val_r + VB'(1);
        if (val_r == '1) begin
          idx_nxt   = '0;
          state_nxt = S_CNT_RD;
        end
      end
      // count: read entry, read its bin, write bin plus one
      S_CNT_RD: begin
        stk_re      = 1'b1;
        stk_raddr_a = idx_r;
        state_nxt   = S_CNT_HIST;
      end
      S_CNT_HIST: begin
        hist_re    = 1'b1;
        hist_raddr = rd_a_r.val;
        state_nxt  = S_CNT_WR;
      end
      S_CNT_WR: begin
        hist_we    = 1'b1;
        hist_waddr = rd_a_r.val;
        hist_wdata = hist_rd_r + CW'(1);
        if (CW'(idx_r) == count_r - CW'(1)) begin
          val_nxt   = '0;
          pos_nxt   = count_r;
          state_nxt = S_FILL_RD;
        end else begin
          idx_nxt   = idx_r + AW'(1);
          state_nxt = S_CNT_RD;
        end
      end
      // refill from the top downward with ascending values
      S_FILL_RD: begin
        hist_re    = 1'b1;
        hist_raddr = val_r;
        state_nxt  = S_FILL_LD;
      end
      S_FILL_LD: begin
        run_nxt   = hist_rd_r;
        state_nxt = S_FILL_WR;
      end
      S_FILL_WR: begin
        if (run_r != '0 && pos_r != '0) begin
          stk_we    = 1'b1;
          stk_waddr = AW'(pos_r - CW'(1));
          stk_wdata = '{pmax: largest_r, val: val_r};
          pos_nxt   = pos_r - CW'(1);
          run_nxt   = run_r - CW'(1);
        end else if (pos_r == '0 || val_r == '1) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          val_nxt   = val_r + VB'(1);
          state_nxt = S_FILL_RD;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // result register
  always_comb begin
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_ready;
    if (out_load) begin
      out_nxt.popped_value  = swcs_pkg::VAL_W'(res_pop);
      out_nxt.entry_count   = swcs_pkg::CNT_W'(count_nxt);
      out_nxt.largest_value = swcs_pkg::VAL_W'(largest_nxt);
      out_nxt.status        = res_st;
      out_valid_nxt         = 1'b1;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      largest_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      largest_r   <= largest_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // sort counters and result payload
  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    val_r <= val_nxt;
    pos_r <= pos_nxt;
    run_r <= run_nxt;
    out_r <= out_nxt;
  end

endmodule

@@ rtl/swcs_chk.sv @@
`timescale 1ns / 1ps
// port checker for stack_with_counting_sort and its bind statement
// depends on swcs_pkg
module swcs_chk #(
  parameter int unsigned STACK_DEPTH = swcs_pkg::STACK_DEPTH_DEF
) (
  input logic                clk,
  input logic                rst_n,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input swcs_pkg::out_item_t out_data
);

  localparam int unsigned CW = swcs_pkg::CNT_W;
  localparam logic [CW-1:0] FULL_CNT = CW'(STACK_DEPTH);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // pop on empty leaves an empty stack
  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == swcs_pkg::ST_EMPTY |->
      out_data.entry_count == '0 && out_data.popped_value == '0 &&
      out_data.largest_value == '0)
    else $error("pop on empty reported a held entry");

  // push on full reports a full stack and no popped value
  a_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == swcs_pkg::ST_FULL |->
      out_data.entry_count == FULL_CNT && out_data.popped_value == '0)
    else $error("full flag with wrong count");

  // no new request while a result waits unserved
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("request taken while result stalled");

endmodule

bind stack_with_counting_sort swcs_chk #(.STACK_DEPTH(STACK_DEPTH)) u_swcs_chk (.*);
